/* rtl/fpw_pkg.sv */
// Package for the four-level page walker: widths, masks, codes and shared types.
package fpw_pkg;

    localparam int PHYS_ADDR_BITS = 52;
    localparam int ADDR_W         = 52;
    localparam int VADDR_W        = 48;
    localparam int ENTRY_W        = 64;
    localparam int IDX_W          = 9;
    localparam int S_DATA_W       = 112;
    localparam int M_DATA_W       = 112;

    localparam logic [ADDR_W-1:0] PHYS_MASK  = (ADDR_W'(1) << PHYS_ADDR_BITS) - ADDR_W'(1);
    localparam logic [ADDR_W-1:0] TABLE_MASK = PHYS_MASK & ~ADDR_W'(52'hFFF);
    localparam logic [ADDR_W-1:0] GIB_MASK   = PHYS_MASK & 52'hFFFFFC0000000;
    localparam logic [ADDR_W-1:0] MIB_MASK   = PHYS_MASK & 52'hFFFFFFFE00000;
    localparam logic [ADDR_W-1:0] GIB_OFFSET = 52'h3FFFFFFF;
    localparam logic [ADDR_W-1:0] MIB_OFFSET = 52'h1FFFFF;
    localparam logic [ADDR_W-1:0] KIB_OFFSET = 52'hFFF;

    localparam int ENTRY_PRESENT_BIT = 0;
    localparam int ENTRY_LARGE_BIT   = 7;

    localparam logic MODE_XLATE = 1'b0;
    localparam logic MODE_RESP  = 1'b1;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] PS_4K = 2'd0;
    localparam logic [1:0] PS_2M = 2'd1;
    localparam logic [1:0] PS_1G = 2'd2;

    localparam logic [1:0] LVL_TOP = 2'd0;
    localparam logic [1:0] LVL_PDP = 2'd1;
    localparam logic [1:0] LVL_DIR = 2'd2;
    localparam logic [1:0] LVL_TBL = 2'd3;

    typedef struct packed {
        logic               busy;
        logic [1:0]         level;
        logic [VADDR_W-1:0] saved_vaddr;
    } t_walk_state;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] read_addr;
        logic [ADDR_W-1:0] phys_addr;
        logic              fault;
        logic [1:0]        leaf_size;
    } t_result;

    function automatic logic [IDX_W-1:0] level_index(input logic [VADDR_W-1:0] va,
                                                      input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            LVL_TOP: idx = va[47:39];
            LVL_PDP: idx = va[38:30];
            LVL_DIR: idx = va[29:21];
            LVL_TBL: idx = va[20:12];
            default: idx = va[47:39];
        endcase
        return idx;
    endfunction

    function automatic logic [ADDR_W-1:0] entry_offset(input logic [IDX_W-1:0] idx);
        return {{(ADDR_W-IDX_W-3){1'b0}}, idx, 3'b000};
    endfunction

endpackage

/* rtl/fpw_step.sv */
// Single-word walk step: next walk state and the result word for one input word.
module fpw_step (
    input  logic                          i_mode,
    input  logic [fpw_pkg::VADDR_W-1:0]   i_vaddr,
    input  logic [fpw_pkg::ENTRY_W-1:0]   i_entry,
    input  logic [fpw_pkg::ADDR_W-1:0]    i_root,
    input  fpw_pkg::t_walk_state          i_state,
    output fpw_pkg::t_walk_state          o_state,
    output logic                          o_res_vld,
    output fpw_pkg::t_result              o_res
);
    import fpw_pkg::*;

    logic [ADDR_W-1:0] w_entry;
    logic              w_present;
    logic              w_large;
    logic [1:0]        w_next_lvl;

    assign w_entry    = i_entry[ADDR_W-1:0];
    assign w_present  = i_entry[ENTRY_PRESENT_BIT];
    assign w_large    = i_entry[ENTRY_LARGE_BIT];
    assign w_next_lvl = i_state.level + 2'd1;

    always_comb begin
        o_state   = i_state;
        o_res_vld = 1'b0;
        o_res     = '0;
        if (i_mode == MODE_XLATE) begin
            if (!i_state.busy) begin
                o_state.busy        = 1'b1;
                o_state.level       = LVL_TOP;
                o_state.saved_vaddr = i_vaddr;
                o_res_vld           = 1'b1;
                o_res.kind          = KIND_READ;
                o_res.read_addr     = (i_root & TABLE_MASK)
                                    | entry_offset(level_index(i_vaddr, LVL_TOP));
            end
        end else if (i_state.busy) begin
            o_res_vld = 1'b1;
            if (!w_present) begin
                o_state.busy  = 1'b0;
                o_state.level = LVL_TOP;
                o_res.kind    = KIND_DONE;
                o_res.fault   = 1'b1;
            end else if ((i_state.level == LVL_PDP) && w_large) begin
                o_state.busy    = 1'b0;
                o_state.level   = LVL_TOP;
                o_res.kind      = KIND_DONE;
                o_res.phys_addr = (w_entry & GIB_MASK)
                                | ({4'b0, i_state.saved_vaddr} & GIB_OFFSET);
                o_res.leaf_size = PS_1G;
            end else if ((i_state.level == LVL_DIR) && w_large) begin
                o_state.busy    = 1'b0;
                o_state.level   = LVL_TOP;
                o_res.kind      = KIND_DONE;
                o_res.phys_addr = (w_entry & MIB_MASK)
                                | ({4'b0, i_state.saved_vaddr} & MIB_OFFSET);
                o_res.leaf_size = PS_2M;
            end else if (i_state.level == LVL_TBL) begin
                o_state.busy    = 1'b0;
                o_state.level   = LVL_TOP;
                o_res.kind      = KIND_DONE;
                o_res.phys_addr = (w_entry & TABLE_MASK)
                                | ({4'b0, i_state.saved_vaddr} & KIB_OFFSET);
                o_res.leaf_size = PS_4K;
            end else begin
                o_state.level   = w_next_lvl;
                o_res.kind      = KIND_READ;
                o_res.read_addr = (w_entry & TABLE_MASK)
                                | entry_offset(level_index(i_state.saved_vaddr, w_next_lvl));
            end
        end
    end

endmodule

/* rtl/four_level_page_walk_top.sv */
// Top level of the four-level page walker: input register, walk state, output register.
//
//  channel   dir  tdata                                         tuser
//  s_axis    in   virt_addr[47:0], entry_data[111:48]           mode
//  m_axis    out  read_addr[51:0], phys_addr[103:52],           kind
//                 fault[104], leaf_size[106:105], zero pad
//  cfg       in   i_cfg_wr_data = root_table_addr, i_cfg_wr_en
//
//  One word per cycle while m_axis does not stall: a word is registered, then stepped,
//  and its result, if it has one, lands in the output register that drives tvalid.
//  The walk state register is the only loop, closed through the combinational step.
//  Synchronous active-low reset clears the walk state, root address and valids.
//  A stall on m_axis holds the input register and drops s_axis_tready once it is full.
module four_level_page_walk_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [fpw_pkg::ADDR_W-1:0]     i_cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [fpw_pkg::S_DATA_W-1:0]   s_axis_tdata,   // virt_addr, entry_data
    input  logic                           s_axis_tuser,   // mode
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [fpw_pkg::M_DATA_W-1:0]   m_axis_tdata,   // read_addr, phys_addr, fault, leaf_size
    output logic                           m_axis_tuser    // kind
);
    import fpw_pkg::*;

    logic               r_in_vld;
    logic               r_in_mode;
    logic [VADDR_W-1:0] r_in_vaddr;
    logic [ENTRY_W-1:0] r_in_entry;
    t_walk_state        r_state;
    t_walk_state        n_state;
    logic [ADDR_W-1:0]  r_root;
    logic               r_out_vld;
    t_result            r_out;
    t_result            n_out;
    logic               n_out_vld;
    logic               w_adv;

    assign w_adv         = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || w_adv;

    fpw_step u_step (
        .i_mode    (r_in_mode),
        .i_vaddr   (r_in_vaddr),
        .i_entry   (r_in_entry),
        .i_root    (r_root),
        .i_state   (r_state),
        .o_state   (n_state),
        .o_res_vld (n_out_vld),
        .o_res     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_state   <= '0;
            r_root    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_root <= i_cfg_wr_data;
            end
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (r_in_vld && w_adv) begin
                r_state <= n_state;
            end
            if (w_adv) begin
                r_out_vld <= r_in_vld && n_out_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_mode  <= s_axis_tuser;
            r_in_vaddr <= s_axis_tdata[VADDR_W-1:0];
            r_in_entry <= s_axis_tdata[VADDR_W+ENTRY_W-1:VADDR_W];
        end
        if (w_adv && r_in_vld && n_out_vld) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {(M_DATA_W-2*ADDR_W-3)'(0), r_out.leaf_size, r_out.fault,
                            r_out.phys_addr, r_out.read_addr};

`ifndef SYNTH
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_state.busy && !r_out_vld && !r_in_vld)
        else $error("walker not idle after reset");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.fault) |-> (r_out.phys_addr == '0 && r_out.leaf_size == PS_4K))
        else $error("fault word carries an address or page size");

    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.kind == KIND_READ)
            |-> (r_out.phys_addr == '0 && !r_out.fault && r_out.leaf_size == PS_4K))
        else $error("read request word carries finish fields");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && w_adv && n_out_vld && n_out.kind == KIND_DONE)
            |=> (!r_state.busy && r_state.level == LVL_TOP))
        else $error("walker still busy after finish");

    a_psize_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.leaf_size != 2'd3))
        else $error("illegal page size code");
`endif

endmodule

/* sim/page_walk_checker.sv */
// Checker for the four-level page walker: predicts each result word and compares it.
module page_walk_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [fpw_pkg::ADDR_W-1:0]     i_cfg_wr_data,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [fpw_pkg::S_DATA_W-1:0]   s_axis_tdata,   // virt_addr, entry_data
    input  logic                           s_axis_tuser,   // mode
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [fpw_pkg::M_DATA_W-1:0]   m_axis_tdata,   // read_addr, phys_addr, fault, leaf_size
    input  logic                           m_axis_tuser,   // kind
    output int                             o_mismatches,
    output int                             o_pending
);
    import fpw_pkg::*;

    logic [ADDR_W-1:0]  root_addr;
    logic               walk_busy;
    logic [1:0]         walk_lvl;
    logic [VADDR_W-1:0] walk_va;
    t_result            expected_q[$];
    t_result            predicted;
    t_result            observed;
    t_result            oldest;
    int                 mismatch_cnt = 0;

    // byte offset of the 9-bit index for this level within its table
    function automatic logic [ADDR_W-1:0] index_offset(input logic [VADDR_W-1:0] va,
                                                       input logic [1:0] lvl);
        logic [VADDR_W-1:0] sh;
        sh = va >> (39 - 9 * int'(lvl));
        return {{(ADDR_W-12){1'b0}}, sh[8:0], 3'b000};
    endfunction

    function automatic logic walk_step(input logic mode, input logic [VADDR_W-1:0] va,
                                       input logic [ENTRY_W-1:0] entry, output t_result res);
        logic [ADDR_W-1:0] ent;
        logic [ADDR_W-1:0] va_ext;
        res    = '0;
        ent    = entry[ADDR_W-1:0];
        va_ext = ADDR_W'(walk_va);
        if (mode == MODE_XLATE) begin
            if (walk_busy)
                return 1'b0;
            walk_va       = va;
            walk_lvl      = LVL_TOP;
            walk_busy     = 1'b1;
            res.kind      = KIND_READ;
            res.read_addr = (root_addr & TABLE_MASK) | index_offset(va, LVL_TOP);
            return 1'b1;
        end
        if (!walk_busy)
            return 1'b0;
        res.kind = KIND_DONE;
        if (!entry[ENTRY_PRESENT_BIT]) begin
            res.fault = 1'b1;
        end else if (walk_lvl == LVL_PDP && entry[ENTRY_LARGE_BIT]) begin
            res.phys_addr = (ent & GIB_MASK) | (va_ext & GIB_OFFSET);
            res.leaf_size = PS_1G;
        end else if (walk_lvl == LVL_DIR && entry[ENTRY_LARGE_BIT]) begin
            res.phys_addr = (ent & MIB_MASK) | (va_ext & MIB_OFFSET);
            res.leaf_size = PS_2M;
        end else if (walk_lvl == LVL_TBL) begin
            res.phys_addr = (ent & TABLE_MASK) | (va_ext & KIB_OFFSET);
            res.leaf_size = PS_4K;
        end else begin
            walk_lvl      = walk_lvl + 2'd1;
            res.kind      = KIND_READ;
            res.read_addr = (ent & TABLE_MASK) | index_offset(walk_va, walk_lvl);
            return 1'b1;
        end
        walk_busy = 1'b0;
        walk_lvl  = LVL_TOP;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            root_addr = '0;
            walk_busy = 1'b0;
            walk_lvl  = LVL_TOP;
            walk_va   = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_wr_en)
                root_addr = i_cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) begin
                if (walk_step(s_axis_tuser, s_axis_tdata[VADDR_W-1:0],
                              s_axis_tdata[VADDR_W +: ENTRY_W], predicted))
                    expected_q.push_back(predicted);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                observed.kind      = m_axis_tuser;
                observed.read_addr = m_axis_tdata[ADDR_W-1:0];
                observed.phys_addr = m_axis_tdata[ADDR_W +: ADDR_W];
                observed.fault     = m_axis_tdata[2*ADDR_W];
                observed.leaf_size = m_axis_tdata[2*ADDR_W+1 +: 2];
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected word kind=%0d read=%h phys=%h fault=%0d size=%0d",
                             $time, observed.kind, observed.read_addr, observed.phys_addr,
                             observed.fault, observed.leaf_size);
                    mismatch_cnt++;
                end else begin
                    oldest = expected_q.pop_front();
                    if (observed !== oldest) begin
                        $display("%0t: expected kind=%0d read=%h phys=%h fault=%0d size=%0d",
                                 $time, oldest.kind, oldest.read_addr, oldest.phys_addr,
                                 oldest.fault, oldest.leaf_size);
                        $display("%0t:   actual kind=%0d read=%h phys=%h fault=%0d size=%0d",
                                 $time, observed.kind, observed.read_addr, observed.phys_addr,
                                 observed.fault, observed.leaf_size);
                        mismatch_cnt++;
                    end
                end
            end
        end
        o_pending    <= expected_q.size();
        o_mismatches <= mismatch_cnt;
    end

endmodule

/* sim/tb.sv */
// Testbench top for the four-level page walker: stimulus, flow control and verdict.
module tb;
    import fpw_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 450;
    localparam int PHASES       = 5;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [ADDR_W-1:0]     i_cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;   // virt_addr, entry_data
    logic                  s_axis_tuser;   // mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [M_DATA_W-1:0]   m_axis_tdata;   // read_addr, phys_addr, fault, leaf_size
    logic                  m_axis_tuser;   // kind

    int   fail_count;
    int   pending;
    int   cycle_cnt = 0;
    int   results_sent = 0;
    int   rx_stall = 0;
    logic tx_fast = 1'b0;
    logic rx_fast = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    four_level_page_walk_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    page_walk_checker walk_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_mismatches  (fail_count),
        .o_pending     (pending)
    );

    // result side: random stall after each accepted word, none when rx_fast is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_stall = 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_stall = rx_fast ? 0 : $urandom_range(0, 13);
            m_axis_tready <= (rx_stall == 0);
        end else if (rx_stall != 0) begin
            rx_stall = rx_stall - 1;
            m_axis_tready <= (rx_stall == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("four_level_page_walk_top test failed");
            $finish;
        end
    end

    function automatic logic [ENTRY_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VADDR_W-1:0] pick_va();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return VADDR_W'({$urandom, $urandom});
    endfunction

    // mostly present entries; large bit left random
    function automatic logic [ENTRY_W-1:0] pick_entry();
        int               sel;
        logic [ENTRY_W-1:0] e;
        sel = $urandom_range(0, 99);
        e   = {$urandom, $urandom};
        if (sel < 3)
            return '1;
        if (sel < 6)
            return 64'h1;
        e[ENTRY_PRESENT_BIT] = (sel >= 12);
        return e;
    endfunction

    task automatic send_word(input logic mode, input logic [VADDR_W-1:0] va,
                             input logic [ENTRY_W-1:0] entry);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {entry, va};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_root(input logic [ADDR_W-1:0] value);
        i_cfg_wr_data <= value;
        i_cfg_wr_en   <= 1'b1;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // one well-formed walk with random entries, plus occasional stray words
    task automatic run_walk();
        logic [1:0]         lvl;
        logic [ENTRY_W-1:0] e;
        logic               done;
        tx_fast  = ($urandom_range(0, 7) == 0);
        rx_fast <= ($urandom_range(0, 7) == 0);
        send_word(MODE_XLATE, pick_va(), rand64());
        results_sent++;
        lvl  = LVL_TOP;
        done = 1'b0;
        while (!done) begin
            if ($urandom_range(0, 15) == 0)
                send_word(MODE_XLATE, pick_va(), rand64());
            e = pick_entry();
            send_word(MODE_RESP, pick_va(), e);
            results_sent++;
            if (!e[ENTRY_PRESENT_BIT] || lvl == LVL_TBL ||
                (e[ENTRY_LARGE_BIT] && (lvl == LVL_PDP || lvl == LVL_DIR)))
                done = 1'b1;
            else
                lvl = lvl + 2'd1;
        end
        if ($urandom_range(0, 9) == 0)
            send_word(MODE_RESP, pick_va(), pick_entry());
    endtask

    initial begin
        logic [ADDR_W-1:0] root;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_XLATE;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_root('1);
        // response with no walk running
        send_word(MODE_RESP, '0, '1);
        // plain 4 KiB walk at address zero
        send_word(MODE_XLATE, '0, '1);
        repeat (4) send_word(MODE_RESP, '0, 64'h1);
        // large bit at top and table levels is ignored; request while busy
        send_word(MODE_XLATE, '1, '0);
        send_word(MODE_RESP, '0, '1);
        send_word(MODE_RESP, '1, 64'hFFFF_FFFF_FFFF_FF7F);
        send_word(MODE_XLATE, pick_va(), rand64());
        send_word(MODE_RESP, '1, 64'hFFFF_FFFF_FFFF_FF7F);
        send_word(MODE_RESP, '0, '1);
        // 1 GiB page
        send_word(MODE_XLATE, 48'h1234_5678_9ABC, rand64());
        send_word(MODE_RESP, pick_va(), 64'h1);
        send_word(MODE_RESP, pick_va(), '1);
        // 2 MiB page
        send_word(MODE_XLATE, 48'h8000_3FFF_FFFF, rand64());
        send_word(MODE_RESP, pick_va(), 64'h1);
        send_word(MODE_RESP, pick_va(), 64'h1);
        send_word(MODE_RESP, pick_va(), 64'h8000_0000_4000_0081);
        // not present at top level, then at directory level
        send_word(MODE_XLATE, pick_va(), rand64());
        send_word(MODE_RESP, pick_va(), '0);
        send_word(MODE_XLATE, '1, rand64());
        send_word(MODE_RESP, pick_va(), 64'h1);
        send_word(MODE_RESP, pick_va(), 64'h1);
        send_word(MODE_RESP, pick_va(), 64'hFFFF_FFFF_FFFF_FFFE);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       root = '0;
                1:       root = '1;
                2:       root = ADDR_W'({$urandom, $urandom}) & TABLE_MASK;
                default: root = ADDR_W'({$urandom, $urandom});
            endcase
            write_root(root);
            while (results_sent < RANDOM_ITEMS * (p + 1) / PHASES) begin
                run_walk();
                if ($urandom_range(0, 39) == 0)
                    drain_results();
            end
            drain_results();
        end

        if (fail_count == 0)
            $display("four_level_page_walk_top test passed");
        else
            $display("four_level_page_walk_top test failed");
        $finish;
    end

endmodule

/* files.f */
rtl/fpw_pkg.sv
rtl/fpw_step.sv
rtl/four_level_page_walk_top.sv
sim/page_walk_checker.sv
sim/tb.sv
